>>> sv/g711_companding_codec_macros.svh
// assertion helpers used by the codec top file
`ifndef G711_COMPANDING_CODEC_MACROS_SVH
`define G711_COMPANDING_CODEC_MACROS_SVH

// same-cycle implication, checked on rising clk outside reset
`define G711_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on rising clk outside reset
`define G711_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/g711_pkg.sv
package g711_pkg;

    typedef enum logic [2:0] {
        OP_ENC_ALAW  = 3'd0,
        OP_DEC_ALAW  = 3'd1,
        OP_ENC_MULAW = 3'd2,
        OP_DEC_MULAW = 3'd3,
        OP_A_TO_MU   = 3'd4,
        OP_MU_TO_A   = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] pcm;
        logic [7:0]         code;
    } item_t;

    typedef struct packed {
        logic [7:0]         code;
        logic signed [15:0] pcm;
    } result_t;

    localparam logic [7:0]  A_MASK_POS   = 8'hD5;
    localparam logic [7:0]  A_MASK_NEG   = 8'h55;
    localparam logic [15:0] MU_BIAS      = 16'h0084;
    localparam logic [7:0]  MU_MASK_NEG  = 8'h7F;
    localparam logic [7:0]  MU_MASK_POS  = 8'hFF;
    localparam logic [14:0] A_SEG1_BASE  = 15'h0108;
    localparam logic [7:0]  TOP_CODE     = 8'h7F;
    localparam logic [15:0] A_NEG_OFFSET = 16'd8;
    localparam logic [3:0]  SEG_OVER     = 4'd8;

    localparam logic [15:0] SEG_TOP [8] = '{
        16'h00FF, 16'h01FF, 16'h03FF, 16'h07FF,
        16'h0FFF, 16'h1FFF, 16'h3FFF, 16'h7FFF
    };

    localparam logic [7:0] MU_TO_A [128] = '{
        8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd4,
        8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,
        8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,
        8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,
        8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd34,  8'd35,  8'd36,
        8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,
        8'd46,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
        8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,
        8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
        8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,
        8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,  8'd96,
        8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
        8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
        8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
        8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128
    };

    localparam logic [6:0] A_TO_MU [128] = '{
        7'd1,   7'd3,   7'd5,   7'd7,   7'd9,   7'd11,  7'd13,  7'd15,
        7'd16,  7'd17,  7'd18,  7'd19,  7'd20,  7'd21,  7'd22,  7'd23,
        7'd24,  7'd25,  7'd26,  7'd27,  7'd28,  7'd29,  7'd30,  7'd31,
        7'd32,  7'd32,  7'd33,  7'd33,  7'd34,  7'd34,  7'd35,  7'd35,
        7'd36,  7'd37,  7'd38,  7'd39,  7'd40,  7'd41,  7'd42,  7'd43,
        7'd44,  7'd45,  7'd46,  7'd47,  7'd48,  7'd48,  7'd49,  7'd49,
        7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,  7'd56,  7'd57,
        7'd58,  7'd59,  7'd60,  7'd61,  7'd62,  7'd63,  7'd64,  7'd64,
        7'd65,  7'd66,  7'd67,  7'd68,  7'd69,  7'd70,  7'd71,  7'd72,
        7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd78,  7'd79,  7'd79,
        7'd80,  7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,
        7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd94,  7'd95,
        7'd96,  7'd97,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
        7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111,
        7'd112, 7'd113, 7'd114, 7'd115, 7'd116, 7'd117, 7'd118, 7'd119,
        7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125, 7'd126, 7'd127
    };

endpackage

>>> sv/g711_in_if.sv
interface g711_in_if;
    import g711_pkg::*;

    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [15:0] pcm_in;
    logic [7:0]         code_in;

    modport source (output valid, output op, output pcm_in, output code_in, input ready);
    modport sink   (input valid, input op, input pcm_in, input code_in, output ready);
endinterface

>>> sv/g711_out_if.sv
interface g711_out_if;
    import g711_pkg::*;

    logic               valid;
    logic               ready;
    logic [7:0]         code_out;
    logic signed [15:0] pcm_out;

    modport source (output valid, output code_out, output pcm_out, input ready);
    modport sink   (input valid, input code_out, input pcm_out, output ready);
endinterface

>>> sv/g711_core.sv
module g711_core (
    input  g711_pkg::item_t   item,
    output g711_pkg::result_t result
);
    import g711_pkg::*;

    // segment 0..7, or SEG_OVER past the last end point
    function automatic logic [3:0] find_seg(input logic [15:0] mag);
        logic [3:0] s;
        s = SEG_OVER;
        for (int i = 7; i >= 0; i--)
        begin
            if (mag <= SEG_TOP[i])
            begin
                s = 4'(i);
            end
        end
        return s;
    endfunction

    logic [15:0] neg_mag;
    logic [15:0] a_mag;
    logic [15:0] mu_mag;
    logic [3:0]  a_seg;
    logic [3:0]  mu_seg;
    logic [3:0]  a_mant;
    logic [3:0]  mu_mant;
    logic [7:0]  a_mask;
    logic [7:0]  mu_mask;
    logic [7:0]  enc_a;
    logic [7:0]  enc_mu;
    logic [7:0]  dv_a;
    logic [7:0]  dv_mu;
    logic [14:0] dt_a;
    logic [14:0] dt_mu;
    logic signed [15:0] dec_a;
    logic signed [15:0] dec_mu;
    logic [7:0]  xc_a_mu;
    logic [7:0]  xc_mu_a;
    logic [7:0]  mu_a_val;

    always_comb
    begin
        // magnitude of a negative sample, unsigned so -32768 gives 32768
        neg_mag = ~item.pcm + 16'd1;

        // a-law encode
        if (!item.pcm[15])
        begin
            a_mask = A_MASK_POS;
            a_mag  = {1'b0, item.pcm[14:0]};
        end
        else
        begin
            a_mask = A_MASK_NEG;
            a_mag  = (neg_mag < A_NEG_OFFSET) ? 16'd0 : neg_mag - A_NEG_OFFSET;
        end
        a_seg = find_seg(a_mag);
        if (a_seg < 4'd2)
        begin
            a_mant = a_mag[7:4];
        end
        else
        begin
            a_mant = 4'(a_mag >> (a_seg + 4'd3));
        end
        enc_a = (a_seg >= SEG_OVER) ? (TOP_CODE ^ a_mask) : ({a_seg[2:0], a_mant} ^ a_mask);

        // mu-law encode, bias added before the segment compare
        if (item.pcm[15])
        begin
            mu_mask = MU_MASK_NEG;
            mu_mag  = neg_mag + MU_BIAS;
        end
        else
        begin
            mu_mask = MU_MASK_POS;
            mu_mag  = {1'b0, item.pcm[14:0]} + MU_BIAS;
        end
        mu_seg  = find_seg(mu_mag);
        mu_mant = 4'(mu_mag >> (mu_seg + 4'd3));
        enc_mu  = (mu_seg >= SEG_OVER) ? (TOP_CODE ^ mu_mask)
                                       : ({mu_seg[2:0], mu_mant} ^ mu_mask);

        // a-law decode
        dv_a = item.code ^ A_MASK_NEG;
        if (dv_a[6:4] == 3'd0)
        begin
            dt_a = {7'd0, dv_a[3:0], 4'h8};
        end
        else
        begin
            dt_a = ({7'd0, dv_a[3:0], 4'h0} + A_SEG1_BASE) << (dv_a[6:4] - 3'd1);
        end
        dec_a = dv_a[7] ? $signed({1'b0, dt_a}) : -$signed({1'b0, dt_a});

        // mu-law decode
        dv_mu  = ~item.code;
        dt_mu  = ({8'd0, dv_mu[3:0], 3'd0} + MU_BIAS[14:0]) << dv_mu[6:4];
        dec_mu = dv_mu[7] ? $signed(MU_BIAS - {1'b0, dt_mu})
                          : $signed({1'b0, dt_mu} - MU_BIAS);

        // transcoding through the tables, both signs share one index
        xc_a_mu  = (item.code[7] ? MU_MASK_POS : MU_MASK_NEG)
                 ^ {1'b0, A_TO_MU[item.code[6:0] ^ A_MASK_NEG[6:0]]};
        mu_a_val = MU_TO_A[~item.code[6:0]] - 8'd1;
        xc_mu_a  = (item.code[7] ? A_MASK_POS : A_MASK_NEG) ^ mu_a_val;

        result = '0;
        unique case (item.op)
            OP_ENC_ALAW:  result.code = enc_a;
            OP_DEC_ALAW:  result.pcm  = dec_a;
            OP_ENC_MULAW: result.code = enc_mu;
            OP_DEC_MULAW: result.pcm  = dec_mu;
            OP_A_TO_MU:   result.code = xc_a_mu;
            OP_MU_TO_A:   result.code = xc_mu_a;
            default:      result      = '0;
        endcase
    end
endmodule

>>> sv/g711_companding_codec.sv
// G.711 companding codec: each transfer on in_ch carries op, pcm_in and code_in and yields
// exactly one transfer on out_ch with code_out and pcm_out (the field an operation does not
// produce is zero, and the unused op codes 6 and 7 give zero in both). The block takes one
// item per cycle sustained while out_ch.ready stays high; an item is first held in the item
// register, then its result is loaded into the result register from the item register through
// the segment compare, shift and table lookup once the result slot is free, and is offered on
// out_ch from there. in_ch.ready depends on out_ch.ready through the two stages, so a full
// pipeline that is stalled at the output stops accepting, while an empty slot keeps taking
// items.
`include "g711_companding_codec_macros.svh"

module g711_companding_codec (
    input  logic       clk,
    input  logic       rst_n,
    g711_in_if.sink    in_ch,
    g711_out_if.source out_ch
);
    import g711_pkg::*;

    // item stage
    logic    item_valid_reg;
    logic    item_valid_next;
    item_t   item_reg;

    // result stage
    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;
    result_t res_comb;

    logic    res_ready;
    logic    item_ready;
    logic    in_xfer;
    logic    item_move;

    // result slot frees when empty or when its transfer happens now
    assign res_ready  = !res_valid_reg || out_ch.ready;
    assign item_ready = !item_valid_reg || res_ready;
    assign in_xfer    = in_ch.valid && item_ready;
    assign item_move  = item_valid_reg && res_ready;

    assign in_ch.ready = item_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_ready)
        begin
            item_valid_next = in_ch.valid;
        end
        res_valid_next = res_valid_reg;
        if (res_ready)
        begin
            res_valid_next = item_valid_reg;
        end
    end

    // codec logic between the two registers
    g711_core u_core (
        .item   (item_reg),
        .result (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.op   <= in_ch.op;
            item_reg.pcm  <= in_ch.pcm_in;
            item_reg.code <= in_ch.code_in;
        end
        if (item_move)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_ch.valid    = res_valid_reg;
    assign out_ch.code_out = res_reg.code;
    assign out_ch.pcm_out  = res_reg.pcm;

    // an item in the first stage moves on whenever the result slot is free
    `G711_ASSERT_NXT(a_item_moves, item_valid_reg && res_ready, res_valid_reg, "item lost between stages")
    // full item stage with a blocked result stage must stall the input
    `G711_ASSERT_IMP(a_full_stall, item_valid_reg && !res_ready, !in_ch.ready, "input taken while full")
    // an operation fills at most one result field
    `G711_ASSERT_IMP(a_one_field, out_ch.valid, (out_ch.code_out == 8'd0) || (out_ch.pcm_out == 16'sd0), "both result fields set")
    // decoded samples stay inside the codec range
    `G711_ASSERT_IMP(a_pcm_range, out_ch.valid, (out_ch.pcm_out <= 16'sd32256) && (out_ch.pcm_out >= -16'sd32256), "decoded sample out of range")
endmodule
